FILE: rtl/rtpdj_pkg.sv
// ----------------------------------------------------------------------------
// rtpdj_pkg
// Shared types and constants of the RTP de-jitter scheduler.
// ----------------------------------------------------------------------------
package rtpdj_pkg;

  // Input beat: arrival or tick
  typedef struct packed {
    logic        mode;
    logic [1:0]  rtp_version;
    logic [6:0]  payload_type;
    logic [31:0] rtp_timestamp;
    logic [63:0] now_time;
    logic [15:0] packet_tag;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_tag;
    logic [63:0] departure_time;
    logic        clock_reset;
    logic        last;
  } result_t;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPTED  = 2'd0;
  localparam logic [1:0] KIND_NOT_RTP   = 2'd1;
  localparam logic [1:0] KIND_FULL      = 2'd2;
  localparam logic [1:0] KIND_RELEASED  = 2'd3;

  // Input modes
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  localparam logic [1:0]  RTP_V2        = 2'd2;
  localparam logic [6:0]  PT_MPEG2_TS   = 7'd33;
  localparam logic [14:0] SCALE_90K     = 15'd300;
  localparam logic [14:0] SCALE_MS      = 15'd27000;
  localparam logic [14:0] AVG_KEEP      = 15'd149;
  localparam logic [7:0]  AVG_WEIGHT    = 8'd150;
  localparam logic [63:0] GAP_LIMIT     = 64'd8100000;
  localparam logic [63:0] JITTER_LIMIT  = 64'd2700000;
  localparam logic [63:0] RELEASE_SLACK = 64'd26999;
  localparam logic [63:0] STAMP_RESET   = 64'h0000_0001_0000_0000;
  localparam logic [33:0] DELAY_RESET   = 34'd5400000;
  localparam int          MAX_RESULTS   = 32;

  // Divide by 150 as a halving then a divide by 75: for n below 2^63,
  // floor(n / 75) = (n * DIV_RECIP) >> 70, with DIV_RECIP rounded up
  localparam logic [71:0] DIV_RECIP_FULL = (72'd1 << 70) / 72'(AVG_WEIGHT >> 1) + 72'd1;
  localparam logic [63:0] DIV_RECIP      = DIV_RECIP_FULL[63:0];

  // Register map
  localparam logic REG_BUFFER_DELAY = 1'b0;

  // True when a signed value lies outside [-lim, lim]
  function automatic logic out_of_band(logic [63:0] v, logic [63:0] lim);
    return ($signed(v) > $signed(lim)) || ($signed(v) < -$signed(lim));
  endfunction

endpackage

FILE: rtl/rtpdj_ram.sv
// ----------------------------------------------------------------------------
// rtpdj_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtpdj_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rtp_dejitter_scheduler.sv
// ----------------------------------------------------------------------------
// rtp_dejitter_scheduler
// RTP de-jitter buffer: timestamp unwrap, clock recovery and a date-sorted
// playout queue held in a circular RAM.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  command   start / busy                 cmd    (cmd_t)
//  result    result_valid (no stall)      result (result_t)
//  config    APB psel/penable/pready      buffer_delay at byte 0
//
// A version 2 arrival keeps busy high through the scaling multiply, the gap
// check and, unless the reference resets, the jitter check and the smoothing
// (multiply by 149, then a four-step reciprocal multiply for the divide by
// 150), then the departure sum and, unless the queue is full, the walk back
// from the tail to insert the entry. A tick on a non-empty queue keeps busy high while it releases due entries.
// Reset clears the queue (head, tail, fill) at once; the RAM needs no clear.
// Results are shown for one cycle each; the receiver cannot stall them.
module rtp_dejitter_scheduler #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rtpdj_pkg::cmd_t     cmd,
  output logic                result_valid,
  output rtpdj_pkg::result_t  result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);

  import rtpdj_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = 64 + TAG_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_GAP    = 5'd2;
  localparam logic [4:0] S_E1     = 5'd3;
  localparam logic [4:0] S_E2     = 5'd4;
  localparam logic [4:0] S_DEV    = 5'd5;
  localparam logic [4:0] S_DIV0   = 5'd6;
  localparam logic [4:0] S_DIV    = 5'd7;
  localparam logic [4:0] S_DIVEND = 5'd8;
  localparam logic [4:0] S_DEP1   = 5'd9;
  localparam logic [4:0] S_DEP2   = 5'd10;
  localparam logic [4:0] S_DEP3   = 5'd11;
  localparam logic [4:0] S_DEP4   = 5'd12;
  localparam logic [4:0] S_INS    = 5'd13;
  localparam logic [4:0] S_SH     = 5'd14;
  localparam logic [4:0] S_PUT    = 5'd15;
  localparam logic [4:0] S_TK     = 5'd16;

  logic [4:0]          state;
  logic [33:0]         buffer_delay;
  logic [63:0]         unwrapped_stamp, last_clock, ref_clock, ref_wall, smoothed;
  logic [63:0]         clk_val, wall, tmp, e_val, dep, limit;
  logic [63:0]         mul_a, acc;
  logic [14:0]         mul_b;
  logic                mul_ret;
  logic [63:0]         div_q;
  logic [127:0]        div_acc;
  logic                div_neg;
  logic [1:0]          div_cnt;
  logic [TAG_BITS-1:0] tag;
  logic                rst_flag;
  logic [PW-1:0]       head, tail, rd_ptr, rd_ptr_next, put_ptr;
  logic [FW-1:0]       fill, pos;
  logic [5:0]          rel_cnt;
  logic [63:0]         pend_date;
  logic [TAG_BITS-1:0] pend_tag;
  logic                pend_v;

  logic                mem_we;
  logic [PW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata, rd_q;
  logic [63:0]         rd_date;
  logic [TAG_BITS-1:0] rd_tag;

  logic [31:0]         ts_diff;
  logic [63:0]         stamp_new;
  logic [64:0]         limit_sum;
  logic [63:0]         gap_d, dev_d;
  logic                due;
  logic [63:0]         div_mag;
  logic [31:0]         pp_a, pp_b;
  logic [63:0]         pp;
  logic [127:0]        pp_wide;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
  endfunction

  assign busy    = (state != S_IDLE);
  assign pready  = 1'b1;
  assign prdata  = (paddr[3] == REG_BUFFER_DELAY) ? {30'b0, buffer_delay} : 64'b0;
  assign rd_date = rd_q[TAG_BITS +: 64];
  assign rd_tag  = rd_q[TAG_BITS-1:0];

  // Unwrap: add the signed 32-bit step between stamps
  assign ts_diff   = cmd.rtp_timestamp - unwrapped_stamp[31:0];
  assign stamp_new = unwrapped_stamp + {{32{ts_diff[31]}}, ts_diff};
  assign limit_sum = {1'b0, cmd.now_time} + {1'b0, RELEASE_SLACK};
  assign gap_d     = last_clock - clk_val;
  assign dev_d     = e_val - smoothed;
  assign due       = (fill != '0) && (rd_date <= limit) && (rel_cnt != 6'(MAX_RESULTS));
  assign div_mag   = acc[63] ? -acc : acc;

  // Reciprocal divide: one 32x32 partial product per cycle
  always_comb begin
    pp_a = div_cnt[0] ? div_q[63:32] : div_q[31:0];
    pp_b = div_cnt[1] ? DIV_RECIP[63:32] : DIV_RECIP[31:0];
    pp   = pp_a * pp_b;
    unique case (div_cnt)
      2'd0: begin
        pp_wide = {64'b0, pp};
      end
      2'd3: begin
        pp_wide = {pp, 64'b0};
      end
      default: begin
        pp_wide = {32'b0, pp, 32'b0};
      end
    endcase
  end

  // Queue RAM addressing: read address is the next pointer, so data lines up
  always_comb begin
    rd_ptr_next = rd_ptr;
    mem_we      = 1'b0;
    mem_waddr   = put_ptr;
    mem_wdata   = {dep, tag};
    unique case (state)
      S_IDLE: begin
        rd_ptr_next = head;
      end
      S_INS: begin
        rd_ptr_next = ptr_dec(tail);
      end
      S_SH: begin
        if (rd_date > dep) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_inc(rd_ptr);
          mem_wdata = rd_q;
          if (pos != FW'(1)) begin
            rd_ptr_next = ptr_dec(rd_ptr);
          end
        end
      end
      S_PUT: begin
        mem_we = 1'b1;
      end
      S_TK: begin
        if (due) begin
          rd_ptr_next = ptr_inc(head);
        end
      end
      default: begin
        rd_ptr_next = rd_ptr;
      end
    endcase
  end

  rtpdj_ram #(
    .WIDTH(MW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_ptr_next),
    .rdata(rd_q)
  );

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_delay <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_BUFFER_DELAY)) begin
      buffer_delay <= pwdata[33:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    rd_ptr       <= rd_ptr_next;
    result_valid <= 1'b0;
    if (rst) begin
      state           <= S_IDLE;
      unwrapped_stamp <= STAMP_RESET;
      last_clock      <= '0;
      ref_clock       <= '0;
      ref_wall        <= '0;
      smoothed        <= '0;
      head            <= '0;
      tail            <= '0;
      fill            <= '0;
      pend_v          <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tag      <= TAG_BITS'(cmd.packet_tag);
            wall     <= cmd.now_time;
            rst_flag <= 1'b0;
            if (cmd.mode == MODE_TICK) begin
              // Saturate the release limit
              limit   <= limit_sum[64] ? '1 : limit_sum[63:0];
              rel_cnt <= '0;
              pend_v  <= 1'b0;
              if (fill != '0) begin
                state <= S_TK;
              end
            end else if (cmd.rtp_version != RTP_V2) begin
              result_valid          <= 1'b1;
              result.kind           <= KIND_NOT_RTP;
              result.out_tag        <= 16'(TAG_BITS'(cmd.packet_tag));
              result.departure_time <= '0;
              result.clock_reset    <= 1'b0;
              result.last           <= 1'b1;
            end else begin
              unwrapped_stamp <= stamp_new;
              mul_a   <= stamp_new;
              mul_b   <= (cmd.payload_type == PT_MPEG2_TS) ? SCALE_90K : SCALE_MS;
              acc     <= '0;
              mul_ret <= 1'b0;
              state   <= S_MUL;
            end
          end
        end
        // Shift-add multiply by a small constant
        S_MUL: begin
          if (mul_b == '0) begin
            if (!mul_ret) begin
              clk_val <= acc;
              state   <= S_GAP;
            end else begin
              state <= S_DIV0;
            end
          end else begin
            if (mul_b[0]) begin
              acc <= acc + mul_a;
            end
            mul_a <= {mul_a[62:0], 1'b0};
            mul_b <= {1'b0, mul_b[14:1]};
          end
        end
        S_GAP: begin
          if (out_of_band(gap_d, GAP_LIMIT)) begin
            smoothed   <= '0;
            ref_clock  <= clk_val;
            last_clock <= clk_val;
            ref_wall   <= wall;
            rst_flag   <= 1'b1;
            state      <= S_DEP1;
          end else begin
            last_clock <= clk_val;
            tmp        <= ref_clock + wall;
            state      <= S_E1;
          end
        end
        S_E1: begin
          tmp   <= tmp - ref_wall;
          state <= S_E2;
        end
        S_E2: begin
          e_val <= tmp - clk_val;
          state <= S_DEV;
        end
        S_DEV: begin
          if (out_of_band(dev_d, JITTER_LIMIT)) begin
            smoothed   <= '0;
            ref_clock  <= clk_val;
            last_clock <= clk_val;
            ref_wall   <= wall;
            rst_flag   <= 1'b1;
            state      <= S_DEP1;
          end else begin
            mul_a   <= smoothed;
            mul_b   <= AVG_KEEP;
            acc     <= e_val;
            mul_ret <= 1'b1;
            state   <= S_MUL;
          end
        end
        // Halve the magnitude, then multiply by the reciprocal of 75
        S_DIV0: begin
          div_neg <= acc[63];
          div_q   <= {1'b0, div_mag[63:1]};
          div_acc <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_acc <= div_acc + pp_wide;
          div_cnt <= div_cnt + 2'd1;
          if (div_cnt == 2'd3) begin
            state <= S_DIVEND;
          end
        end
        // Restore the sign, truncating toward zero
        S_DIVEND: begin
          smoothed <= div_neg ? -{6'b0, div_acc[127:70]} : {6'b0, div_acc[127:70]};
          state    <= S_DEP1;
        end
        S_DEP1: begin
          tmp   <= ref_wall + clk_val;
          state <= S_DEP2;
        end
        S_DEP2: begin
          tmp   <= tmp + smoothed;
          state <= S_DEP3;
        end
        S_DEP3: begin
          tmp   <= tmp - ref_clock;
          state <= S_DEP4;
        end
        S_DEP4: begin
          dep   <= tmp + {30'b0, buffer_delay};
          state <= S_INS;
        end
        // Drop when full, else walk back from the tail
        S_INS: begin
          if (fill == FW'(QUEUE_DEPTH)) begin
            result_valid          <= 1'b1;
            result.kind           <= KIND_FULL;
            result.out_tag        <= 16'(tag);
            result.departure_time <= dep;
            result.clock_reset    <= rst_flag;
            result.last           <= 1'b1;
            state                 <= S_IDLE;
          end else if (fill == '0) begin
            put_ptr <= tail;
            state   <= S_PUT;
          end else begin
            pos   <= fill;
            state <= S_SH;
          end
        end
        S_SH: begin
          if (rd_date > dep) begin
            put_ptr <= rd_ptr;
            if (pos == FW'(1)) begin
              state <= S_PUT;
            end else begin
              pos <= pos - FW'(1);
            end
          end else begin
            put_ptr <= ptr_inc(rd_ptr);
            state   <= S_PUT;
          end
        end
        S_PUT: begin
          fill                  <= fill + FW'(1);
          tail                  <= ptr_inc(tail);
          result_valid          <= 1'b1;
          result.kind           <= KIND_ACCEPTED;
          result.out_tag        <= 16'(tag);
          result.departure_time <= dep;
          result.clock_reset    <= rst_flag;
          result.last           <= 1'b1;
          state                 <= S_IDLE;
        end
        // Release due entries; hold one back to mark the last beat
        S_TK: begin
          if (due) begin
            if (pend_v) begin
              result_valid          <= 1'b1;
              result.kind           <= KIND_RELEASED;
              result.out_tag        <= 16'(pend_tag);
              result.departure_time <= pend_date;
              result.clock_reset    <= 1'b0;
              result.last           <= 1'b0;
            end
            pend_v    <= 1'b1;
            pend_date <= rd_date;
            pend_tag  <= rd_tag;
            head      <= ptr_inc(head);
            fill      <= fill - FW'(1);
            rel_cnt   <= rel_cnt + 6'd1;
          end else begin
            if (pend_v) begin
              result_valid          <= 1'b1;
              result.kind           <= KIND_RELEASED;
              result.out_tag        <= 16'(pend_tag);
              result.departure_time <= pend_date;
              result.clock_reset    <= 1'b0;
              result.last           <= 1'b1;
            end
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/rtp_dejitter_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_dejitter_scheduler_test
// Self-checking bench: arrivals and ticks are fed through start/busy, every
// result beat is compared with a behavioural copy of the scheduler, and the
// playout delay is changed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module rtp_dejitter_scheduler_test;
  import rtpdj_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  rtp_dejitter_scheduler uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [33:0] m_delay;
  logic [63:0] m_stamp, m_last_clk, m_ref_clk, m_ref_wall;
  logic signed [63:0] m_offset;
  logic [63:0] m_date[$];
  logic [15:0] m_tag[$];

  cmd_t    pending_cmds[$];
  result_t expected_beats[$];
  int      errors = 0;
  int      idle_pct = 0;
  logic    hold_off = 1'b0;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic outside(logic [63:0] v, logic [63:0] lim);
    return ($signed(v) > $signed(lim)) || ($signed(v) < -$signed(lim));
  endfunction

  function automatic logic update_reference(logic [63:0] c, logic [63:0] wall);
    logic [63:0] e, sum;
    if (outside(m_last_clk - c, GAP_LIMIT)) begin
      m_offset = 0; m_ref_clk = c; m_last_clk = c; m_ref_wall = wall;
      return 1'b1;
    end
    m_last_clk = c;
    e = m_ref_clk + wall - m_ref_wall - c;
    if (outside(e - m_offset, JITTER_LIMIT)) begin
      m_offset = 0; m_ref_clk = c; m_ref_wall = wall;
      return 1'b1;
    end
    sum = m_offset * 64'd149 + e;
    m_offset = $signed(sum) / 64'sd150;
    return 1'b0;
  endfunction

  // Predict the result beats of one accepted command
  task automatic predict_schedule(cmd_t c);
    result_t r;
    logic [63:0] lim, t, ck, dep;
    logic rs;
    int n, pos;
    if (c.mode == MODE_TICK) begin
      lim = (c.now_time > 64'hFFFF_FFFF_FFFF_FFFF - RELEASE_SLACK) ?
            64'hFFFF_FFFF_FFFF_FFFF : c.now_time + RELEASE_SLACK;
      n = 0;
      while (m_date.size() > 0 && n < MAX_RESULTS && m_date[0] <= lim) begin
        r = '{kind: KIND_RELEASED, out_tag: m_tag[0], departure_time: m_date[0],
              clock_reset: 1'b0, last: 1'b0};
        void'(m_date.pop_front()); void'(m_tag.pop_front());
        expected_beats.push_back(r);
        n++;
      end
      if (n > 0) expected_beats[expected_beats.size()-1].last = 1'b1;
      return;
    end
    if (c.rtp_version != RTP_V2) begin
      expected_beats.push_back('{KIND_NOT_RTP, c.packet_tag, 64'd0, 1'b0, 1'b1});
      return;
    end
    t = (64'h1_8000_0000 + c.rtp_timestamp - m_stamp[31:0]) & 64'hFFFF_FFFF;
    m_stamp = m_stamp + t - 64'h8000_0000;
    ck = m_stamp * ((c.payload_type == PT_MPEG2_TS) ? 64'd300 : 64'd27000);
    rs = update_reference(ck, c.now_time);
    dep = m_ref_wall + (ck + m_offset - m_ref_clk) + m_delay;
    if (m_date.size() >= 32) begin
      expected_beats.push_back('{KIND_FULL, c.packet_tag, dep, rs, 1'b1});
      return;
    end
    pos = m_date.size();
    while (pos > 0 && m_date[pos-1] > dep) pos--;
    m_date.insert(pos, dep);
    m_tag.insert(pos, c.packet_tag);
    expected_beats.push_back('{KIND_ACCEPTED, c.packet_tag, dep, rs, 1'b1});
  endtask

  // Driver: present the next command, drop start once a beat is taken
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_schedule(cmd);
        if (pending_cmds.size() > 0 && !hold_off &&
            $urandom_range(99) >= idle_pct) begin
          cmd <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_cmds.size() > 0 && !hold_off &&
                   $urandom_range(99) >= idle_pct) begin
        cmd <= pending_cmds.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    result_t w;
    if (!rst && result_valid) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", result.out_tag, 0);
      end else begin
        w = expected_beats.pop_front();
        if (result.kind != w.kind) report("kind", result.kind, w.kind);
        if (result.out_tag != w.out_tag) report("tag", result.out_tag, w.out_tag);
        if (result.departure_time != w.departure_time)
          report("departure", result.departure_time, w.departure_time);
        if (result.clock_reset != w.clock_reset)
          report("clock_reset", result.clock_reset, w.clock_reset);
        if (result.last != w.last) report("last", result.last, w.last);
      end
    end
  end

  // Wait until the block has drained
  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_beats.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_delay(logic [33:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {30'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_delay = v;
  endtask

  function automatic cmd_t arrival(logic [1:0] ver, logic [6:0] pt, logic [31:0] ts,
                                   logic [63:0] now, logic [15:0] tag);
    return '{MODE_ARRIVAL, ver, pt, ts, now, tag};
  endfunction

  function automatic cmd_t tick(logic [63:0] now);
    cmd_t c;
    c = cmd_t'(122'({$urandom, $urandom, $urandom, $urandom}));
    c.mode = MODE_TICK;
    c.now_time = now;
    return c;
  endfunction

  // Random stream: mostly steady 90 kHz or ms streams with some jitter
  task automatic random_phase(int count);
    logic [31:0] ts;
    logic [63:0] wall;
    logic [6:0] pt;
    cmd_t c;
    ts = $urandom; wall = {$urandom, $urandom} >> $urandom_range(40);
    pt = $urandom_range(1) ? PT_MPEG2_TS : 7'($urandom);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: c = cmd_t'(122'({$urandom, $urandom, $urandom, $urandom}));
        1, 2: c = tick(wall + ($urandom_range(1) ? 64'd0 : 64'($urandom_range(2000000))));
        3: c = arrival(RTP_V2, 7'($urandom), $urandom, {$urandom, $urandom},
                       16'($urandom));
        default: begin
          ts = ts + $urandom_range(3000);
          wall = wall + ((pt == PT_MPEG2_TS) ? 64'd300 : 64'd27000) * 64'($urandom_range(3000))
                 + 64'($urandom_range(400000));
          c = arrival(RTP_V2, pt, ts, wall, 16'($urandom));
        end
      endcase
      pending_cmds.push_back(c);
    end
    pending_cmds.push_back(tick(64'hFFFF_FFFF_FFFF_FFFF));
    pending_cmds.push_back(tick(64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  initial begin
    m_delay = DELAY_RESET; m_stamp = STAMP_RESET;
    m_last_clk = 0; m_ref_clk = 0; m_ref_wall = 0; m_offset = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_delay(34'h3_FFFF_FFFF);
    write_delay(DELAY_RESET);

    // directed: bad versions, wrap, both scalings, equal dates, queue full
    pending_cmds.push_back(arrival(2'd0, 7'd127, 32'hFFFF_FFFF, '1, 16'hFFFF));
    pending_cmds.push_back(arrival(2'd1, 7'd0, 0, 0, 16'h0));
    pending_cmds.push_back(arrival(2'd3, 7'd33, 0, 0, 16'h5A5A));
    pending_cmds.push_back(arrival(RTP_V2, PT_MPEG2_TS, 32'hFFFF_FFF0, 64'd1000, 16'h1));
    pending_cmds.push_back(arrival(RTP_V2, PT_MPEG2_TS, 32'h10, 64'd11000, 16'h2));
    pending_cmds.push_back(arrival(RTP_V2, PT_MPEG2_TS, 32'h10, 64'd11000, 16'h3));
    pending_cmds.push_back(arrival(RTP_V2, 7'd96, 32'h20, 64'hFFFF_FFFF_FFFF_0000, 16'h4));
    pending_cmds.push_back(tick(64'd0));
    pending_cmds.push_back(tick(64'hFFFF_FFFF_FFFF_FFF0));
    for (int i = 0; i < 34; i++)
      pending_cmds.push_back(arrival(RTP_V2, PT_MPEG2_TS, 32'(i * 3000),
                                     64'(i * 900000), 16'(i)));
    pending_cmds.push_back(tick(64'hFFFF_FFFF_FFFF_FFFF));
    pending_cmds.push_back(tick(64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    idle_pct = 0;   random_phase(40); drain();
    write_delay(34'd0);
    idle_pct = 54;  random_phase(40);
    // pause the sender until all results are in
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    while (start || busy || expected_beats.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    drain();
    write_delay(34'($urandom) | (34'($urandom_range(3)) << 32));
    idle_pct = 25;  random_phase(45); drain();
    write_delay(34'h3_FFFF_FFFF);
    idle_pct = 0;   random_phase(35); drain();

    if (errors == 0) begin
      $display("** rtp_dejitter_scheduler: PASSED **");
    end else begin
      $display("** rtp_dejitter_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("** rtp_dejitter_scheduler: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rtpdj_pkg.sv
rtl/rtpdj_ram.sv
rtl/rtp_dejitter_scheduler.sv
sim/rtp_dejitter_scheduler_test.sv
